// ----- src/cfp_pkg.sv -----
// ----------------------------------------------------------------------------
// cfp_pkg: shared types and constants of the crc-8 framed command parser
// Field widths, register indexes, codes and the bytewise crc-8 update.
// ----------------------------------------------------------------------------
package cfp_pkg;

  localparam int BYTE_W         = 8;
  localparam int CNT_W          = 32;
  localparam int POS_W          = 9;
  localparam int CFG_IDX_W      = 2;
  localparam int MAX_PAYLOAD_DEF = 64;

  localparam logic [7:0] CRC_POLY  = 8'h07;
  localparam logic [7:0] IDLE_ZERO = 8'h00;
  localparam logic [7:0] IDLE_ONES = 8'hFF;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAGIC    = 2'd0,
    REG_CMD_LOW  = 2'd1,
    REG_CMD_HIGH = 2'd2
  } cfg_reg_t;

  // transaction kind picked by the first byte
  typedef enum logic [1:0] {
    KIND_IDLE    = 2'd0,
    KIND_FRAMED  = 2'd1,
    KIND_LEGACY  = 2'd2,
    KIND_INVALID = 2'd3
  } kind_t;

  // protocol mode reported in summaries
  typedef enum logic [1:0] {
    MODE_UNKNOWN = 2'd0,
    MODE_FRAMED  = 2'd1,
    MODE_LEGACY  = 2'd2
  } mode_t;

  // summary outcome codes
  typedef enum logic [2:0] {
    OUT_OK         = 3'd0,
    OUT_IDLE       = 3'd1,
    OUT_UNKNOWN    = 3'd2,
    OUT_TOO_SHORT  = 3'd3,
    OUT_LEN_LARGE  = 3'd4,
    OUT_INCOMPLETE = 3'd5
  } outcome_t;

  // one queue slot: the payload word and/or the summary word of one byte
  typedef struct packed {
    logic              pay_v;
    logic [BYTE_W-1:0] pay_byte;
    logic              sum_v;
    logic              accepted;
    outcome_t          outcome;
    mode_t             mode;
    logic [BYTE_W-1:0] seq;
    logic [BYTE_W-1:0] cmd;
    logic [BYTE_W-1:0] len;
    logic              crc_ok;
    logic [CNT_W-1:0]  frames;
    logic [CNT_W-1:0]  crc_errs;
    logic [CNT_W-1:0]  seq_errs;
  } slot_t;

  // crc-8, msb first, one byte
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) c = {c[6:0], 1'b0} ^ CRC_POLY;
      else      c = {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// ----- src/cfp_byte_if.sv -----
// ----------------------------------------------------------------------------
// cfp_byte_if: received byte channel
// Valid/ready channel carrying one byte of a transaction and its last flag.
// ----------------------------------------------------------------------------
interface cfp_byte_if
  import cfp_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;
  logic              last_byte;

  modport source (output valid, output rx_byte, output last_byte, input ready);
  modport sink   (input valid, input rx_byte, input last_byte, output ready);
endinterface

// ----- src/cfp_result_if.sv -----
// ----------------------------------------------------------------------------
// cfp_result_if: result channel
// Valid/ready channel carrying payload words and transaction summaries.
// ----------------------------------------------------------------------------
interface cfp_result_if
  import cfp_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              item_kind;
  logic [BYTE_W-1:0] payload_value;
  logic              accepted;
  logic [2:0]        outcome;
  logic [1:0]        protocol_mode;
  logic [BYTE_W-1:0] frame_sequence;
  logic [BYTE_W-1:0] frame_command;
  logic [BYTE_W-1:0] payload_length;
  logic              crc_ok;
  logic [CNT_W-1:0]  frames_seen;
  logic [CNT_W-1:0]  crc_errors;
  logic [CNT_W-1:0]  sequence_errors;

  modport source (
    output valid, output item_kind, output payload_value, output accepted,
    output outcome, output protocol_mode, output frame_sequence,
    output frame_command, output payload_length, output crc_ok,
    output frames_seen, output crc_errors, output sequence_errors,
    input ready
  );
  modport sink (
    input valid, input item_kind, input payload_value, input accepted,
    input outcome, input protocol_mode, input frame_sequence,
    input frame_command, input payload_length, input crc_ok,
    input frames_seen, input crc_errors, input sequence_errors,
    output ready
  );
endinterface

// ----- src/cfp_cfg_if.sv -----
// ----------------------------------------------------------------------------
// cfp_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and its write data.
// ----------------------------------------------------------------------------
interface cfp_cfg_if
  import cfp_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [BYTE_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- src/crc8_framed_command_parser_core.sv -----
// ----------------------------------------------------------------------------
// crc8_framed_command_parser_core: crc-8 framed command parser
// Parses framed and legacy command transactions byte by byte, emits payload
// words and an end of transaction summary with error counters.
// ----------------------------------------------------------------------------
// Usage
//   rx_bytes : one byte of a transaction per word, last_byte on the final one
//   results  : payload words (item_kind 0) as the bytes arrive, then one
//              summary word (item_kind 1) for the final byte
//   cfg      : register writes (magic, command range low/high), always ready;
//              write only while no word is in flight
// Timing
//   one byte is taken every cycle while the result queue has a free slot; all
//   parsing and crc work for a byte is done in the cycle it is taken and its
//   words are registered into the result queue; a byte that yields a payload
//   word and a summary sends both over the single result port, which sets the rate
// Reset (rst, synchronous): parser state, counters and the result queue are
//   cleared and the registers take their defaults
// Stall: a two-slot result queue keeps bytes flowing while a result waits;
//   rx_bytes.ready falls only when both slots hold unsent words
// ----------------------------------------------------------------------------
module crc8_framed_command_parser_core
  import cfp_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic   clk,
  input  logic   rst,
  cfp_byte_if.sink     rx_bytes,
  cfp_result_if.source results,
  cfp_cfg_if.sink      cfg
);

  localparam logic [BYTE_W-1:0] MAX_LEN = BYTE_W'(MAX_PAYLOAD);
  localparam logic [POS_W-1:0]  POS_MAX = '1;
  localparam int DEPTH = 2;
  localparam int PTR_W = 1;

  // configuration registers
  logic [BYTE_W-1:0] request_magic;
  logic [BYTE_W-1:0] command_range_low;
  logic [BYTE_W-1:0] command_range_high;

  // parser state
  logic [POS_W-1:0]  byte_position, byte_position_next;
  kind_t             current_kind, current_kind_next;
  mode_t             mode_reg, mode_reg_next;
  logic [BYTE_W-1:0] seq_reg, seq_reg_next;
  logic [BYTE_W-1:0] cmd_reg, cmd_reg_next;
  logic [BYTE_W-1:0] len_reg, len_reg_next;
  logic [BYTE_W-1:0] running_crc, running_crc_next;
  logic [BYTE_W-1:0] got_crc, got_crc_next;
  logic [BYTE_W-1:0] previous_sequence, previous_sequence_next;
  logic [CNT_W-1:0]  frame_counter, frame_counter_next;
  logic [CNT_W-1:0]  crc_error_counter, crc_error_counter_next;
  logic [CNT_W-1:0]  seq_error_counter, seq_error_counter_next;

  // result queue
  slot_t             slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [PTR_W:0]    count;
  logic              pay_done;
  slot_t             slot_new;
  slot_t             head;

  logic              in_acc, out_acc, push, pop;
  logic [BYTE_W-1:0] b;
  logic              emit_pay;
  logic [PTR_W:0]    pay_end;
  logic [PTR_W:0]    unused_ptr;
  logic [9:0]        total;
  logic [9:0]        frame_end;
  logic [9:0]        pay_limit;
  logic [BYTE_W-1:0] seq_expect;
  logic              show_pay;

  assign unused_ptr = '0;
  assign pay_end    = unused_ptr;

  assign b       = rx_bytes.rx_byte;
  assign in_acc  = rx_bytes.valid && rx_bytes.ready;
  assign out_acc = results.valid && results.ready;
  assign rx_bytes.ready = (count < (PTR_W+1)'(DEPTH));
  assign cfg.ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      request_magic      <= 8'd165;
      command_range_low  <= 8'd48;
      command_range_high <= 8'd63;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_MAGIC:    request_magic      <= cfg.data;
        REG_CMD_LOW:  command_range_low  <= cfg.data;
        REG_CMD_HIGH: command_range_high <= cfg.data;
        default: ;
      endcase
    end
  end

  // byte parsing and summary
  always_comb begin
    byte_position_next     = byte_position;
    current_kind_next      = current_kind;
    mode_reg_next          = mode_reg;
    seq_reg_next           = seq_reg;
    cmd_reg_next           = cmd_reg;
    len_reg_next           = len_reg;
    running_crc_next       = running_crc;
    got_crc_next           = got_crc;
    previous_sequence_next = previous_sequence;
    frame_counter_next     = frame_counter;
    crc_error_counter_next = crc_error_counter;
    seq_error_counter_next = seq_error_counter;
    emit_pay               = 1'b0;
    slot_new               = '0;
    pay_limit              = 10'(len_reg) + 10'd4;
    total                  = 10'(byte_position) + 10'd1;
    frame_end              = '0;
    seq_expect             = previous_sequence + 8'd1;

    if (byte_position == '0) begin
      seq_reg_next     = '0;
      cmd_reg_next     = '0;
      len_reg_next     = '0;
      running_crc_next = '0;
      got_crc_next     = '0;
      if (b == request_magic) begin
        current_kind_next = KIND_FRAMED;
        mode_reg_next     = MODE_FRAMED;
        running_crc_next  = crc8_byte(8'h00, b);
      end else if (b >= command_range_low && b <= command_range_high) begin
        current_kind_next = KIND_LEGACY;
        mode_reg_next     = MODE_LEGACY;
        cmd_reg_next      = b;
      end else if (b == IDLE_ZERO || b == IDLE_ONES) begin
        current_kind_next = KIND_IDLE;
      end else begin
        current_kind_next = KIND_INVALID;
      end
    end else if (current_kind == KIND_FRAMED) begin
      if (byte_position <= POS_W'(3)) begin
        case (byte_position[1:0])
          2'd1:    seq_reg_next = b;
          2'd2:    cmd_reg_next = b;
          default: len_reg_next = b;
        endcase
        running_crc_next = crc8_byte(running_crc, b);
      end else if (len_reg <= MAX_LEN) begin
        if (10'(byte_position) < pay_limit) begin
          running_crc_next = crc8_byte(running_crc, b);
          emit_pay         = 1'b1;
        end else if (10'(byte_position) == pay_limit) begin
          got_crc_next = b;
        end
      end
    end else if (current_kind == KIND_LEGACY) begin
      if (len_reg < MAX_LEN) begin
        len_reg_next = len_reg + 8'd1;
        emit_pay     = 1'b1;
      end
    end

    frame_end = 10'(len_reg_next) + 10'd5;

    slot_new.pay_v    = emit_pay;
    slot_new.pay_byte = b;
    slot_new.sum_v    = rx_bytes.last_byte;

    if (!rx_bytes.last_byte) begin
      byte_position_next = (byte_position < POS_MAX) ? byte_position + POS_W'(1) : POS_MAX;
    end else begin
      byte_position_next = '0;
      case (current_kind_next)
        KIND_FRAMED: begin
          if (total < 10'd5) begin
            slot_new.outcome = OUT_TOO_SHORT;
          end else begin
            slot_new.seq = seq_reg_next;
            slot_new.cmd = cmd_reg_next;
            slot_new.len = len_reg_next;
            if (len_reg_next > MAX_LEN) begin
              slot_new.outcome = OUT_LEN_LARGE;
            end else if (total < frame_end) begin
              slot_new.outcome = OUT_INCOMPLETE;
            end else begin
              slot_new.crc_ok = (got_crc_next == running_crc_next);
              if (got_crc_next != running_crc_next) begin
                crc_error_counter_next = crc_error_counter + 32'd1;
              end
              // sequence check once a frame has been seen
              if (frame_counter != '0 && seq_reg_next != seq_expect &&
                  seq_reg_next != '0) begin
                seq_error_counter_next = seq_error_counter + 32'd1;
              end
              previous_sequence_next = seq_reg_next;
              frame_counter_next     = frame_counter + 32'd1;
              slot_new.accepted      = 1'b1;
              slot_new.outcome       = OUT_OK;
            end
          end
        end
        KIND_LEGACY: begin
          slot_new.cmd       = cmd_reg_next;
          slot_new.len       = len_reg_next;
          slot_new.crc_ok    = 1'b1;
          frame_counter_next = frame_counter + 32'd1;
          slot_new.accepted  = 1'b1;
          slot_new.outcome   = OUT_OK;
        end
        KIND_IDLE: slot_new.outcome = OUT_IDLE;
        default:   slot_new.outcome = OUT_UNKNOWN;
      endcase
      slot_new.mode     = mode_reg_next;
      slot_new.frames   = frame_counter_next;
      slot_new.crc_errs = crc_error_counter_next;
      slot_new.seq_errs = seq_error_counter_next;
    end
  end

  // parser state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position     <= '0;
      current_kind      <= KIND_IDLE;
      mode_reg          <= MODE_UNKNOWN;
      seq_reg           <= '0;
      cmd_reg           <= '0;
      len_reg           <= '0;
      running_crc       <= '0;
      got_crc           <= '0;
      previous_sequence <= '0;
      frame_counter     <= '0;
      crc_error_counter <= '0;
      seq_error_counter <= '0;
    end else if (in_acc) begin
      byte_position     <= byte_position_next;
      current_kind      <= current_kind_next;
      mode_reg          <= mode_reg_next;
      seq_reg           <= seq_reg_next;
      cmd_reg           <= cmd_reg_next;
      len_reg           <= len_reg_next;
      running_crc       <= running_crc_next;
      got_crc           <= got_crc_next;
      previous_sequence <= previous_sequence_next;
      frame_counter     <= frame_counter_next;
      crc_error_counter <= crc_error_counter_next;
      seq_error_counter <= seq_error_counter_next;
    end
  end

  // queue control: a slot leaves once its last word is taken
  assign head     = slots[rd_ptr];
  assign show_pay = head.pay_v && !pay_done;
  assign push     = in_acc && (emit_pay || rx_bytes.last_byte);
  assign pop      = out_acc && (!show_pay || !head.sum_v);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= slot_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      count    <= '0;
      pay_done <= 1'b0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PTR_W'(1);
      if (pop) begin
        rd_ptr   <= rd_ptr + PTR_W'(1);
        pay_done <= 1'b0;
      end else if (out_acc) begin
        pay_done <= 1'b1;
      end
      count <= count + (push ? (PTR_W+1)'(1) : '0) - (pop ? (PTR_W+1)'(1) : '0)
               + pay_end;
    end
  end

  // result word from the head slot
  assign results.valid           = (count != '0);
  assign results.item_kind       = !show_pay;
  assign results.payload_value   = show_pay ? head.pay_byte : '0;
  assign results.accepted        = show_pay ? 1'b0 : head.accepted;
  assign results.outcome         = show_pay ? OUT_OK : head.outcome;
  assign results.protocol_mode   = show_pay ? MODE_UNKNOWN : head.mode;
  assign results.frame_sequence  = show_pay ? '0 : head.seq;
  assign results.frame_command   = show_pay ? '0 : head.cmd;
  assign results.payload_length  = show_pay ? '0 : head.len;
  assign results.crc_ok          = show_pay ? 1'b0 : head.crc_ok;
  assign results.frames_seen     = show_pay ? '0 : head.frames;
  assign results.crc_errors      = show_pay ? '0 : head.crc_errs;
  assign results.sequence_errors = show_pay ? '0 : head.seq_errs;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (PTR_W+1)'(DEPTH))
    else $error("result queue overfilled");

  a_push_has_word: assert property (@(posedge clk) disable iff (rst)
    push |-> (slot_new.pay_v || slot_new.sum_v))
    else $error("empty slot pushed");

  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    (in_acc && rx_bytes.last_byte) |=> (byte_position == '0))
    else $error("byte position not cleared after last byte");

  a_frame_step: assert property (@(posedge clk) disable iff (rst)
    !in_acc |=> $stable(frame_counter))
    else $error("frame counter moved without a byte");

  a_pay_done_pair: assert property (@(posedge clk) disable iff (rst)
    pay_done |-> (count != '0 && head.pay_v && head.sum_v))
    else $error("payload marked sent on a slot without a summary");

endmodule
